### rtl/core/brq_pkg.sv
// Shared types and constants of the byte ring queue.
package brq_pkg;

	localparam int QS_W = 11;
	localparam logic [QS_W-1:0] QS_RESET = 11'd1024;

	localparam logic [2:0] KIND_PUSH    = 3'd0;
	localparam logic [2:0] KIND_POP     = 3'd1;
	localparam logic [2:0] KIND_DROP    = 3'd2;
	localparam logic [2:0] KIND_MEASURE = 3'd3;
	localparam logic [2:0] KIND_CLEAR   = 3'd4;

	typedef logic [QS_W-1:0] cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  push_byte;
		logic        wait_when_full;
		logic [10:0] drop_count;
		logic [7:0]  delimiter;
		logic [10:0] max_scan;
	} item_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] pop_byte;
		logic [9:0] packet_length;
		logic [9:0] fill_level;
		logic       overflow_seen;
		logic       was_cleared;
	} result_t;

	typedef struct packed {
		logic accept;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic new_measure;
		logic scan_done;
	} stat_t;

endpackage

### rtl/core/brq_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
interface brq_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### rtl/core/brq_ram.sv
// Generic simple dual-port RAM with registered read.
module brq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### rtl/core/brq_ctrl.sv
// Sequencing state machine of the byte ring queue.
module brq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  brq_pkg::stat_t stat,
	output brq_pkg::cmd_t  cmd
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_n    = stat.new_measure ? S_SCAN : S_FIN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_n = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_n    = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

### rtl/core/brq_dp.sv
// Datapath: positions, fill, packet scan and result register.
module brq_dp #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  brq_pkg::cfg_t            cfg_data,
	input  brq_pkg::item_t           item,
	input  brq_pkg::cmd_t            cmd,
	output brq_pkg::stat_t           stat,
	output brq_pkg::result_t         result,
	output logic                     ram_we,
	output logic [$clog2(DEPTH)-1:0] ram_waddr,
	output logic [7:0]               ram_wdata,
	output logic                     ram_re,
	output logic [$clog2(DEPTH)-1:0] ram_raddr,
	input  logic [7:0]               ram_rdata
);
	localparam int AW = $clog2(DEPTH);
	localparam int SW = $clog2(DEPTH + 1);
	localparam int CW = (SW > brq_pkg::QS_W) ? SW : brq_pkg::QS_W;
	localparam int RW = CW + 1;

	brq_pkg::cfg_t  qsize_q;
	brq_pkg::item_t item_q;
	logic [AW-1:0]  rd_q, wr_q, pos_q;
	logic           ovf_q, cleared_q, odd_q, vld_s1;
	logic [SW-1:0]  fill_q, span_q, i_q, idx_s1, plen_q;
	brq_pkg::result_t res_q;

	logic [CW-1:0] qs_ext, size_c;
	logic [SW-1:0] size, fill_e, span_e;
	logic          bad, issue;
	logic [AW-1:0] rd_e, wr_e, pos_inc;

	logic          ok_n, clr_n, ovf_n;
	logic [7:0]    popb_n;
	logic [SW-1:0] plen_n, fill_n;
	logic [AW-1:0] rd_n, wr_n, rd_inc, wr_inc;
	logic [RW-1:0] drop_sum;

	// ring length clamped to the store
	always_comb begin
		qs_ext = CW'(qsize_q);
		if (qs_ext < CW'(2)) begin
			size_c = CW'(2);
		end else if (qs_ext > CW'(DEPTH)) begin
			size_c = CW'(DEPTH);
		end else begin
			size_c = qs_ext;
		end
	end
	assign size = SW'(size_c);

	assign bad  = (SW'(rd_q) >= size) || (SW'(wr_q) >= size);
	assign rd_e = bad ? '0 : rd_q;
	assign wr_e = bad ? '0 : wr_q;

	always_comb begin
		if (wr_e >= rd_e) begin
			fill_e = SW'(wr_e) - SW'(rd_e);
		end else begin
			fill_e = size - SW'(rd_e) + SW'(wr_e);
		end
		if (CW'(item.max_scan) < CW'(fill_e)) begin
			span_e = SW'(item.max_scan);
		end else begin
			span_e = fill_e;
		end
	end

	assign issue   = cmd.scan && (i_q != span_q);
	assign pos_inc = ((SW'(pos_q) + SW'(1)) >= size) ? '0 : pos_q + AW'(1);
	assign rd_inc  = ((SW'(rd_q) + SW'(1)) >= size) ? '0 : rd_q + AW'(1);
	assign wr_inc  = ((SW'(wr_q) + SW'(1)) >= size) ? '0 : wr_q + AW'(1);

	assign stat = '{
		new_measure: (item.kind == brq_pkg::KIND_MEASURE),
		scan_done:   (i_q == span_q) && !vld_s1
	};

	assign ram_re    = (cmd.accept && item.kind == brq_pkg::KIND_POP) || issue;
	assign ram_raddr = cmd.accept ? rd_e : pos_q;
	assign ram_waddr = wr_q;
	assign ram_wdata = item_q.push_byte;

	always_comb begin
		ok_n     = 1'b0;
		popb_n   = '0;
		plen_n   = '0;
		fill_n   = fill_q;
		clr_n    = cleared_q;
		ovf_n    = ovf_q;
		rd_n     = rd_q;
		wr_n     = wr_q;
		ram_we   = 1'b0;
		drop_sum = RW'(rd_q) + RW'(item_q.drop_count);
		if (drop_sum >= RW'(size)) begin
			drop_sum = drop_sum - RW'(size);
		end
		unique case (item_q.kind)
			brq_pkg::KIND_PUSH: begin
				if (fill_q == size - SW'(1)) begin
					if (!item_q.wait_when_full) begin
						ovf_n = 1'b1;
					end
				end else begin
					ram_we = cmd.finish;
					wr_n   = wr_inc;
					ok_n   = 1'b1;
					fill_n = fill_q + SW'(1);
				end
			end
			brq_pkg::KIND_POP: begin
				if (fill_q != '0) begin
					popb_n = ram_rdata;
					rd_n   = rd_inc;
					ok_n   = 1'b1;
					fill_n = fill_q - SW'(1);
				end
			end
			brq_pkg::KIND_DROP: begin
				if (CW'(item_q.drop_count) <= CW'(fill_q)) begin
					rd_n   = AW'(drop_sum);
					ok_n   = 1'b1;
					fill_n = fill_q - SW'(item_q.drop_count);
				end
			end
			brq_pkg::KIND_MEASURE: begin
				if (span_q == fill_q && odd_q) begin
					rd_n   = '0;
					wr_n   = '0;
					ovf_n  = 1'b0;
					clr_n  = 1'b1;
					fill_n = '0;
				end else begin
					plen_n = plen_q;
				end
				ok_n = (plen_n != '0);
			end
			brq_pkg::KIND_CLEAR: begin
				rd_n   = '0;
				wr_n   = '0;
				ovf_n  = 1'b0;
				clr_n  = 1'b1;
				ok_n   = 1'b1;
				fill_n = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qsize_q <= brq_pkg::QS_RESET;
			rd_q    <= '0;
			wr_q    <= '0;
			ovf_q   <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				qsize_q <= cfg_data;
			end
			if (cmd.accept) begin
				rd_q   <= rd_e;
				wr_q   <= wr_e;
				vld_s1 <= 1'b0;
				if (bad) begin
					ovf_q <= 1'b0;
				end
			end else if (cmd.finish) begin
				rd_q  <= rd_n;
				wr_q  <= wr_n;
				ovf_q <= ovf_n;
			end
			if (cmd.scan) begin
				vld_s1 <= issue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q    <= item;
			cleared_q <= bad;
			fill_q    <= fill_e;
			span_q    <= span_e;
			i_q       <= '0;
			pos_q     <= rd_e;
			odd_q     <= 1'b0;
			plen_q    <= '0;
		end
		if (issue) begin
			pos_q  <= pos_inc;
			i_q    <= i_q + SW'(1);
			idx_s1 <= i_q + SW'(1);
		end
		if (cmd.scan && vld_s1 && ram_rdata == item_q.delimiter) begin
			odd_q <= !odd_q;
			if (odd_q) begin
				plen_q <= idx_s1;
			end
		end
		if (cmd.finish) begin
			res_q.ok            <= ok_n;
			res_q.pop_byte      <= popb_n;
			res_q.packet_length <= 10'(plen_n);
			res_q.fill_level    <= 10'(fill_n);
			res_q.overflow_seen <= ovf_n;
			res_q.was_cleared   <= clr_n;
		end
	end

	assign result = res_q;
endmodule

### rtl/core/byte_ring_queue_with_packet_scan.sv
// Top level of the byte ring queue with packet scan.
// Byte ring queue with packet scan. Each item transaction on items performs one
// operation (push, pop, drop, measure packet, clear) and yields exactly one
// result transaction on results. The ring length comes from the cfg channel
// (reset 1024, clamped to 2..DEPTH), which is always ready and should be written
// only while the queue is idle. Items are handled one at a time: push, pop, drop,
// clear and reserved kinds go through accept, then completion (a pop reads the
// byte store through its registered read port in between); a packet measure goes
// through accept, scan and completion, the scan reading one stored byte per cycle
// over the single read port up to span, the smaller of fill level and max_scan.
// A finished result waits in the output register while the next item is already
// accepted; that item's completion waits until the result is taken.
module byte_ring_queue_with_packet_scan #(
	parameter int DEPTH = 1024
) (
	input logic        clk,
	input logic        arst_n,
	brq_chan_if.sink   cfg,
	brq_chan_if.sink   items,
	brq_chan_if.source results
);
	localparam int AW = $clog2(DEPTH);

	brq_pkg::cmd_t  cmd;
	brq_pkg::stat_t stat;
	logic           ram_we, ram_re;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [7:0]     ram_wdata, ram_rdata;

	assign cfg.ready = 1'b1;

	brq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	brq_dp #(.DEPTH(DEPTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg.valid),
		.cfg_data (cfg.payload),
		.item     (items.payload),
		.cmd      (cmd),
		.stat     (stat),
		.result   (results.payload),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	brq_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);
endmodule

### sim/brq_queue_checker.sv
`timescale 1ns / 100ps
// Checker: watches the channels, predicts each result of the byte ring queue and compares.
module brq_queue_checker #(
	parameter int DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  brq_pkg::cfg_t    cfg_data,
	input  logic             item_valid,
	input  logic             item_ready,
	input  brq_pkg::item_t   item_data,
	input  logic             res_valid,
	input  logic             res_ready,
	input  brq_pkg::result_t res_data,
	input  logic             at_end,
	output int unsigned      fail_count
);

	logic [7:0]       ring_bytes [DEPTH];
	int unsigned      head;
	int unsigned      tail;
	logic             ovf;
	brq_pkg::cfg_t    ring_len_reg;
	brq_pkg::result_t expected_results [$];
	int unsigned      n_bad;
	bit               tallied;

	assign fail_count = n_bad;

	function automatic int unsigned occupancy(input int unsigned len);
		return (tail >= head) ? tail - head : len - (head - tail);
	endfunction

	function automatic void empty_ring();
		head = 0;
		tail = 0;
		ovf = 1'b0;
	endfunction

	function automatic brq_pkg::result_t predict_outcome(input brq_pkg::item_t it);
		brq_pkg::result_t r;
		int unsigned      len;
		int unsigned      fill;
		int unsigned      span;
		int unsigned      hits;
		int unsigned      p;
		r = '0;
		len = int'(ring_len_reg);
		if (len < 2) len = 2;
		if (len > DEPTH) len = DEPTH;
		if (head >= len || tail >= len) begin
			empty_ring();
			r.was_cleared = 1'b1;
		end
		fill = occupancy(len);
		case (it.kind)
			brq_pkg::KIND_PUSH: begin
				if (fill == len - 1) begin
					if (!it.wait_when_full) ovf = 1'b1;
				end else begin
					ring_bytes[tail] = it.push_byte;
					tail = (tail + 1 >= len) ? 0 : tail + 1;
					r.ok = 1'b1;
				end
			end
			brq_pkg::KIND_POP: begin
				if (fill != 0) begin
					r.pop_byte = ring_bytes[head];
					head = (head + 1 >= len) ? 0 : head + 1;
					r.ok = 1'b1;
				end
			end
			brq_pkg::KIND_DROP: begin
				if (int'(it.drop_count) <= fill) begin
					head = head + int'(it.drop_count);
					if (head >= len) head = head - len;
					r.ok = 1'b1;
				end
			end
			brq_pkg::KIND_MEASURE: begin
				span = (fill < int'(it.max_scan)) ? fill : int'(it.max_scan);
				hits = 0;
				for (int unsigned i = 0; i < span; i++) begin
					p = head + i;
					if (p >= len) p = p - len;
					if (ring_bytes[p] == it.delimiter) begin
						hits++;
						if (hits[0] == 1'b0) r.packet_length = 10'(i + 1);
					end
				end
				// odd delimiter count over the whole queue: framing lost
				if (span == fill && hits[0]) begin
					empty_ring();
					r.was_cleared = 1'b1;
					r.packet_length = '0;
				end
				r.ok = (r.packet_length != '0);
			end
			brq_pkg::KIND_CLEAR: begin
				empty_ring();
				r.was_cleared = 1'b1;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.fill_level = 10'(occupancy(len));
		r.overflow_seen = ovf;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		brq_pkg::result_t want;
		if (!arst_n) begin
			empty_ring();
			ring_len_reg = brq_pkg::QS_RESET;
			expected_results.delete();
			n_bad = 0;
			tallied = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) ring_len_reg = cfg_data;
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					if (n_bad < 10)
						$display("%0t: result transaction with nothing expected, fill %0d",
							$time, res_data.fill_level);
					n_bad++;
				end else begin
					want = expected_results.pop_front();
					if (res_data.ok !== want.ok || res_data.pop_byte !== want.pop_byte ||
						res_data.packet_length !== want.packet_length ||
						res_data.fill_level !== want.fill_level ||
						res_data.overflow_seen !== want.overflow_seen ||
						res_data.was_cleared !== want.was_cleared) begin
						if (n_bad < 10) begin
							$display("%0t: expected ok %0d pop %h len %0d fill %0d ovf %0d clr %0d",
								$time, want.ok, want.pop_byte, want.packet_length,
								want.fill_level, want.overflow_seen, want.was_cleared);
							$display("%0t:      got ok %0d pop %h len %0d fill %0d ovf %0d clr %0d",
								$time, res_data.ok, res_data.pop_byte, res_data.packet_length,
								res_data.fill_level, res_data.overflow_seen, res_data.was_cleared);
						end
						n_bad++;
					end
				end
			end
			if (item_valid && item_ready) expected_results.push_back(predict_outcome(item_data));
			if (at_end && !tallied) begin
				tallied = 1'b1;
				if (expected_results.size() != 0) begin
					$display("%0t: %0d results never arrived", $time, expected_results.size());
					n_bad += expected_results.size();
				end
			end
		end
	end

endmodule

### sim/tb_byte_ring_queue_with_packet_scan.sv
`timescale 1ns / 100ps
// Testbench top of the byte ring queue: clock, reset, stimulus and verdict.
module tb_byte_ring_queue_with_packet_scan;

	localparam int          DEPTH = 1024;
	localparam int unsigned CYCLE_LIMIT = 10_000_000;
	localparam int unsigned PHASE_ITEMS = 140;
	localparam logic [2:0]  KIND_RSV_FIRST = 3'd5;
	localparam logic [2:0]  KIND_RSV_LAST = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        at_end = 1'b0;
	bit          steady = 1'b0;
	int unsigned n_sent = 0;
	int unsigned n_done = 0;
	int unsigned n_cycles = 0;
	int unsigned fail_count;

	brq_pkg::cfg_t phase_len [12] = '{11'd4, 11'd0, 11'd2, 11'd1, 11'd16, 11'd3, 11'd2047,
		11'd1024, 11'd64, 11'd7, 11'd300, 11'd1025};

	brq_chan_if #(.payload_t(brq_pkg::cfg_t))    cfg_ch ();
	brq_chan_if #(.payload_t(brq_pkg::item_t))   item_ch ();
	brq_chan_if #(.payload_t(brq_pkg::result_t)) res_ch ();

	byte_ring_queue_with_packet_scan #(.DEPTH(DEPTH)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.items   (item_ch),
		.results (res_ch)
	);

	brq_queue_checker #(.DEPTH(DEPTH)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_ch.valid),
		.cfg_ready  (cfg_ch.ready),
		.cfg_data   (cfg_ch.payload),
		.item_valid (item_ch.valid),
		.item_ready (item_ch.ready),
		.item_data  (item_ch.payload),
		.res_valid  (res_ch.valid),
		.res_ready  (res_ch.ready),
		.res_data   (res_ch.payload),
		.at_end     (at_end),
		.fail_count (fail_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) res_ch.ready <= steady || ($urandom_range(0, 99) >= 13);

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) n_done++;
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic brq_pkg::item_t make_item(input logic [2:0] kind, input logic [7:0] b,
		input logic w, input logic [10:0] drop, input logic [7:0] dl, input logic [10:0] scan);
		brq_pkg::item_t it;
		it.kind = kind;
		it.push_byte = b;
		it.wait_when_full = w;
		it.drop_count = drop;
		it.delimiter = dl;
		it.max_scan = scan;
		return it;
	endfunction

	task automatic send_item(input brq_pkg::item_t it);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 13) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.payload <= it;
		do @(posedge clk); while (!item_ch.ready);
		n_sent++;
		steady = (n_sent >= 700 && n_sent < 1000);
	endtask

	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (n_done != n_sent) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_ring_length(input brq_pkg::cfg_t len);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= len;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [7:0]     dl;
		brq_pkg::cfg_t  cur_len;
		brq_pkg::item_t it;
		int unsigned    made;
		int unsigned    n_payload;
		int unsigned    roll;

		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		res_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty queue, field extremes and framing corner cases at full ring length
		dl = 8'h7E;
		send_item(make_item(brq_pkg::KIND_MEASURE, 8'h00, 1'b0, 11'd0, dl, 11'd1024));
		send_item(make_item(brq_pkg::KIND_POP, 8'h00, 1'b0, 11'd0, dl, 11'd0));
		send_item(make_item(brq_pkg::KIND_DROP, 8'h00, 1'b0, 11'd0, dl, 11'd0));
		send_item(make_item(brq_pkg::KIND_DROP, 8'h00, 1'b0, 11'd1, dl, 11'd0));
		send_item(make_item(brq_pkg::KIND_PUSH, 8'h00, 1'b0, 11'd0, dl, 11'd0));
		send_item(make_item(brq_pkg::KIND_PUSH, 8'hFF, 1'b1, 11'd1024, 8'hFF, 11'd1024));
		send_item(make_item(brq_pkg::KIND_PUSH, dl, 1'b0, 11'd0, dl, 11'd0));
		send_item(make_item(brq_pkg::KIND_PUSH, 8'h01, 1'b0, 11'd0, dl, 11'd0));
		send_item(make_item(brq_pkg::KIND_PUSH, dl, 1'b0, 11'd0, dl, 11'd0));
		send_item(make_item(brq_pkg::KIND_PUSH, 8'h55, 1'b0, 11'd0, dl, 11'd0));
		send_item(make_item(brq_pkg::KIND_MEASURE, 8'h00, 1'b0, 11'd0, dl, 11'd0));
		send_item(make_item(brq_pkg::KIND_MEASURE, 8'h00, 1'b0, 11'd0, dl, 11'd3));
		send_item(make_item(brq_pkg::KIND_MEASURE, 8'h00, 1'b0, 11'd0, dl, 11'd1024));
		send_item(make_item(brq_pkg::KIND_MEASURE, 8'h00, 1'b0, 11'd0, 8'h00, 11'd1024));
		send_item(make_item(brq_pkg::KIND_POP, 8'h00, 1'b0, 11'd0, dl, 11'd0));
		send_item(make_item(brq_pkg::KIND_DROP, 8'h00, 1'b0, 11'd1024, dl, 11'd0));
		send_item(make_item(brq_pkg::KIND_DROP, 8'h00, 1'b0, 11'd1, dl, 11'd0));
		send_item(make_item(brq_pkg::KIND_PUSH, dl, 1'b0, 11'd0, dl, 11'd0));
		send_item(make_item(brq_pkg::KIND_MEASURE, 8'h00, 1'b0, 11'd0, dl, 11'd1024));
		send_item(make_item(brq_pkg::KIND_PUSH, 8'hAA, 1'b1, 11'd0, dl, 11'd0));
		send_item(make_item(KIND_RSV_FIRST, 8'hFF, 1'b1, 11'd1024, 8'hFF, 11'd1024));
		send_item(make_item(KIND_RSV_FIRST + 3'd1, 8'h00, 1'b0, 11'd0, 8'h00, 11'd0));
		send_item(make_item(KIND_RSV_LAST, 8'hFF, 1'b1, 11'd1024, 8'hFF, 11'd1024));
		send_item(make_item(brq_pkg::KIND_CLEAR, 8'hFF, 1'b1, 11'd1024, 8'hFF, 11'd1024));

		cur_len = brq_pkg::QS_RESET;
		foreach (phase_len[ph]) begin
			if (phase_len[ph] > cur_len) begin
				// a longer ring must start empty so no unwritten entry is ever read
				send_item(make_item(brq_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 11'($urandom_range(0, 1024)),
					8'($urandom_range(0, 255)), 11'($urandom_range(0, 1024))));
			end else begin
				// leave bytes queued so a shorter ring may catch positions out of range
				repeat (6) send_item(make_item(brq_pkg::KIND_PUSH, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 11'd0, 8'h00, 11'd0));
			end
			drain();
			write_ring_length(phase_len[ph]);
			cur_len = phase_len[ph];
			dl = 8'($urandom_range(0, 255));
			made = 0;
			while (made < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 30) begin
					n_payload = $urandom_range(0, 6);
					send_item(make_item(brq_pkg::KIND_PUSH, dl, 1'($urandom_range(0, 1)),
						11'($urandom_range(0, 1024)), dl, 11'd0));
					repeat (n_payload) send_item(make_item(brq_pkg::KIND_PUSH,
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 11'd0, dl,
						11'd0));
					send_item(make_item(brq_pkg::KIND_PUSH, dl, 1'($urandom_range(0, 1)),
						11'd0, dl, 11'd0));
					made += n_payload + 2;
					if ($urandom_range(0, 1)) begin
						send_item(make_item(brq_pkg::KIND_MEASURE,
							8'($urandom_range(0, 255)), 1'b0, 11'd0, dl,
							11'($urandom_range(0, 48))));
						made++;
					end
				end else begin
					roll = $urandom_range(0, 99);
					if (roll < 38 || roll >= 95) it.kind = brq_pkg::KIND_PUSH;
					else if (roll < 60) it.kind = brq_pkg::KIND_POP;
					else if (roll < 68) it.kind = brq_pkg::KIND_DROP;
					else if (roll < 88) it.kind = brq_pkg::KIND_MEASURE;
					else if (roll < 91) it.kind = brq_pkg::KIND_CLEAR;
					else it.kind = 3'($urandom_range(KIND_RSV_FIRST, KIND_RSV_LAST));
					it.push_byte = ($urandom_range(0, 99) < 35) ? dl : 8'($urandom_range(0, 255));
					it.wait_when_full = 1'($urandom_range(0, 1));
					roll = $urandom_range(0, 99);
					if (roll < 85) it.drop_count = 11'($urandom_range(0, 4));
					else if (roll < 95) it.drop_count = 11'($urandom_range(0, 64));
					else it.drop_count = 11'($urandom_range(0, 1024));
					it.delimiter = ($urandom_range(0, 99) < 90) ? dl : 8'($urandom_range(0, 255));
					roll = $urandom_range(0, 99);
					if (roll < 70) it.max_scan = 11'($urandom_range(0, 48));
					else if (roll < 95) it.max_scan = 11'($urandom_range(0, 200));
					else it.max_scan = 11'($urandom_range(0, 1024));
					send_item(it);
					made++;
				end
			end
		end

		drain();
		repeat (8) @(negedge clk);
		at_end <= 1'b1;
		@(posedge clk);
		@(negedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
